// ===== rtl/stl_pkg.sv =====
// ----------------------------------------------------------------------------
// stl_pkg
// Shared types, token codes and character tables of the source token lexer.
// ----------------------------------------------------------------------------
`default_nettype none

package stl_pkg;

    localparam int POSITION_BITS_DEF  = 16;
    localparam int MAX_NEST_DEPTH_DEF = 255;
    localparam int TOKENS_PER_BYTE    = 4;

    // three-char shift-assign kinds, and the token kinds beyond the operator range
    localparam logic [6:0] K_LE3   = 7'd19;   // <<=
    localparam logic [6:0] K_GE3   = 7'd23;   // >>=
    localparam logic [6:0] K_WS    = 7'd43;
    localparam logic [6:0] K_NL    = 7'd44;
    localparam logic [6:0] K_NUM   = 7'd45;
    localparam logic [6:0] K_CHAR  = 7'd46;
    localparam logic [6:0] K_STR   = 7'd47;
    localparam logic [6:0] K_IDENT = 7'd48;
    localparam logic [6:0] K_KW0   = 7'd49;
    localparam logic [6:0] K_LINE  = 7'd64;
    localparam logic [6:0] K_BLOCK = 7'd65;
    localparam logic [6:0] K_BAD   = 7'd66;
    localparam logic [6:0] K_END   = 7'd67;

    // diagnostic bits
    localparam logic [7:0] D_UNEXP  = 8'h01;
    localparam logic [7:0] D_UNTERM = 8'h02;
    localparam logic [7:0] D_EMPTY  = 8'h04;
    localparam logic [7:0] D_LONG   = 8'h08;
    localparam logic [7:0] D_LZ     = 8'h10;
    localparam logic [7:0] D_HEX    = 8'h20;
    localparam logic [7:0] D_BIN    = 8'h40;
    localparam logic [7:0] D_BADB   = 8'h80;

    // operator lookups return NO_KIND (bit 7 set) when the byte has no such form
    localparam logic [7:0] NO_KIND = 8'h80;

    localparam logic [14:0] KW_ALL = 15'h7FFF;

    // keyword text, right-justified: char i of a length-L word is byte L-1-i
    localparam logic [127:0] KW_TEXT [15] = '{"true", "false", "if", "else", "switch",
        "case", "default", "while", "for", "in", "break", "continue", "fn",
        "namespace", "enum"};
    localparam logic [3:0] KW_LEN [15] = '{4'd4, 4'd5, 4'd2, 4'd4, 4'd6, 4'd4, 4'd7,
        4'd5, 4'd3, 4'd2, 4'd5, 4'd8, 4'd2, 4'd9, 4'd4};

    typedef struct packed {
        logic [6:0]  kind;
        logic [15:0] start;
        logic [15:0] length;
        logic [31:0] value;
        logic [7:0]  diag;
    } token_t;

    typedef struct packed {
        logic [2:0]       count;
        token_t [TOKENS_PER_BYTE-1:0] tok;
    } bundle_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic is_ident(input logic [7:0] c);
        return is_letter(c) || is_digit(c) || (c == "_");
    endfunction

    function automatic logic [7:0] single_kind(input logic [7:0] c);
        logic [7:0] r;
        case (c)
            "+":     r = 8'd0;
            "-":     r = 8'd3;
            "*":     r = 8'd6;
            "/":     r = 8'd8;
            "%":     r = 8'd10;
            "!":     r = 8'd12;
            "=":     r = 8'd14;
            "<":     r = 8'd16;
            ">":     r = 8'd20;
            "&":     r = 8'd24;
            "|":     r = 8'd27;
            "~":     r = 8'd30;
            "^":     r = 8'd31;
            "?":     r = 8'd33;
            ":":     r = 8'd34;
            ";":     r = 8'd35;
            ",":     r = 8'd36;
            ".":     r = 8'd37;
            "(":     r = 8'd39;
            ")":     r = 8'd40;
            "{":     r = 8'd41;
            "}":     r = 8'd42;
            default: r = NO_KIND;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] double_kind(input logic [7:0] c);
        logic [7:0] r;
        case (c)
            "+":     r = 8'd1;
            "-":     r = 8'd4;
            "<":     r = 8'd18;
            ">":     r = 8'd22;
            "&":     r = 8'd25;
            "|":     r = 8'd28;
            ".":     r = 8'd38;
            default: r = NO_KIND;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] eq_kind(input logic [7:0] c);
        logic [7:0] r;
        case (c)
            "+":     r = 8'd2;
            "-":     r = 8'd5;
            "*":     r = 8'd7;
            "/":     r = 8'd9;
            "%":     r = 8'd11;
            "!":     r = 8'd13;
            "=":     r = 8'd15;
            "<":     r = 8'd17;
            ">":     r = 8'd21;
            "&":     r = 8'd26;
            "|":     r = 8'd29;
            "^":     r = 8'd32;
            default: r = NO_KIND;
        endcase
        return r;
    endfunction

    // keep the keywords whose char at idx equals c
    function automatic logic [14:0] kw_filter(input logic [14:0] mask,
                                              input logic [15:0] idx,
                                              input logic [7:0]  c);
        logic [14:0] r;
        logic [3:0]  p;
        r = '0;
        for (int k = 0; k < 15; k++) begin
            p = KW_LEN[k] - 4'd1 - idx[3:0];
            if (mask[k] && (idx < {12'd0, KW_LEN[k]}) &&
                (KW_TEXT[k][{p, 3'b000} +: 8] == c))
                r[k] = 1'b1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/stl_front.sv =====
// ----------------------------------------------------------------------------
// stl_front
// Lexer state machine: takes one byte a cycle while the queue is not full and forms
// the bundle of tokens that the byte completes.
// ----------------------------------------------------------------------------
`default_nettype none

module stl_front #(
    parameter int POSITION_BITS  = stl_pkg::POSITION_BITS_DEF,
    parameter int MAX_NEST_DEPTH = stl_pkg::MAX_NEST_DEPTH_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output      logic             in_ready,
    input  wire logic [7:0]       in_byte,
    input  wire logic             in_end,
    input  wire logic             q_full,
    output      logic             q_push,
    output      stl_pkg::bundle_t q_bundle
);

    localparam int DW = $clog2(MAX_NEST_DEPTH + 1);

    typedef enum logic [14:0] {
        M_IDLE      = 15'h0001,
        M_OP        = 15'h0002,
        M_LINE      = 15'h0004,
        M_BLK       = 15'h0008,
        M_BLK_SLASH = 15'h0010,
        M_BLK_STAR  = 15'h0020,
        M_NUM_FIRST = 15'h0040,
        M_DEC       = 15'h0080,
        M_HEX       = 15'h0100,
        M_BIN       = 15'h0200,
        M_LIT       = 15'h0400,
        M_LIT_ESC   = 15'h0800,
        M_IDENT     = 15'h1000,
        M_WS        = 15'h2000,
        M_NL        = 15'h4000
    } mode_t;

    typedef struct packed {
        mode_t                   mode;
        logic [7:0]              win;    // pending operator byte, first digit or quote
        logic                    op2;    // two shift chars seen
        logic [POSITION_BITS-1:0] start;
        logic [31:0]             acc;
        logic [DW-1:0]           depth;
        logic [14:0]             kw;
        logic [1:0]              lc;
        logic [7:0]              diag;
        logic [15:0]             len;
    } lex_st_t;

    typedef struct packed {
        lex_st_t          st;
        logic             ok;     // byte consumed
        logic             tv;     // token produced
        stl_pkg::token_t  tok;
    } em_t;

    localparam lex_st_t ST_RESET = '{mode: M_IDLE, win: 8'd0, op2: 1'b0, start: '0,
        acc: 32'd0, depth: '0, kw: stl_pkg::KW_ALL, lc: 2'd0, diag: 8'd0, len: 16'd0};

    function automatic lex_st_t clear(input lex_st_t s);
        lex_st_t r;
        r       = ST_RESET;
        r.start = s.start;
        return r;
    endfunction

    function automatic lex_st_t grow(input lex_st_t s);
        lex_st_t r;
        r = s;
        if (s.len != 16'hFFFF)
            r.len = s.len + 16'd1;
        return r;
    endfunction

    function automatic em_t emit_cur(input lex_st_t s, input logic [6:0] kind,
                                     input logic [31:0] val);
        em_t r;
        r.st  = clear(s);
        r.ok  = 1'b1;
        r.tv  = 1'b1;
        r.tok = '{kind: kind, start: 16'(s.start), length: s.len, value: val, diag: s.diag};
        return r;
    endfunction

    function automatic lex_st_t add_content(input lex_st_t s, input logic [7:0] code);
        lex_st_t r;
        r = s;
        if (s.lc == 2'd0)
            r.acc = {24'd0, code};
        if (s.lc < 2'd2)
            r.lc = s.lc + 2'd1;
        return r;
    endfunction

    function automatic em_t finish_lit(input lex_st_t s);
        lex_st_t n;
        em_t     r;
        n = s;
        if (s.win == "'") begin
            if (s.lc == 2'd0)
                n.diag = n.diag | stl_pkg::D_EMPTY;
            if (s.lc == 2'd2)
                n.diag = n.diag | stl_pkg::D_LONG;
            r = emit_cur(n, stl_pkg::K_CHAR, (s.lc != 2'd0) ? s.acc : 32'd0);
        end else begin
            r = emit_cur(n, stl_pkg::K_STR, 32'd0);
        end
        return r;
    endfunction

    function automatic em_t finish_num(input lex_st_t s);
        logic [6:0] kind;
        kind = |(s.diag & (stl_pkg::D_LZ | stl_pkg::D_HEX | stl_pkg::D_BIN)) ?
               stl_pkg::K_BAD : stl_pkg::K_NUM;
        return emit_cur(s, kind, s.acc);
    endfunction

    function automatic em_t finish_ident(input lex_st_t s);
        logic [6:0]  kind;
        logic [31:0] val;
        kind = stl_pkg::K_IDENT;
        val  = 32'd0;
        for (int k = 0; k < 15; k++) begin
            if (s.kw[k] && (s.len == {12'd0, stl_pkg::KW_LEN[k]})) begin
                kind = stl_pkg::K_KW0 + 7'(k);
                val  = (k == 0) ? 32'd1 : 32'd0;
            end
        end
        return emit_cur(s, kind, val);
    endfunction

    // ends the pending token as if no byte followed
    function automatic em_t flush(input lex_st_t s);
        lex_st_t    n;
        em_t        r;
        logic [7:0] kk;
        n     = s;
        r.st  = clear(s);
        r.ok  = 1'b1;
        r.tv  = 1'b0;
        r.tok = '0;
        kk    = s.op2 ? stl_pkg::double_kind(s.win) : stl_pkg::single_kind(s.win);
        case (s.mode)
            M_OP:        r = emit_cur(s, kk[6:0], 32'd0);
            M_LINE:      r = emit_cur(s, stl_pkg::K_LINE, 32'd0);
            M_BLK, M_BLK_SLASH, M_BLK_STAR:
            begin
                n.diag = n.diag | stl_pkg::D_UNTERM;
                r = emit_cur(n, stl_pkg::K_BLOCK, 32'd0);
            end
            M_NUM_FIRST:
            begin
                n.acc = {24'd0, s.win - 8'd48};
                r = finish_num(n);
            end
            M_DEC, M_HEX, M_BIN: r = finish_num(s);
            M_LIT_ESC:   r = finish_lit(add_content(s, 8'd0));
            M_LIT:       r = finish_lit(s);
            M_IDENT:     r = finish_ident(s);
            M_WS:        r = emit_cur(s, stl_pkg::K_WS, 32'd0);
            M_NL:        r = emit_cur(s, stl_pkg::K_NL, 32'd0);
            default:     r.st = clear(s);
        endcase
        return r;
    endfunction

    function automatic em_t feed(input lex_st_t s, input logic [7:0] c,
                                 input logic [POSITION_BITS-1:0] pos);
        lex_st_t    n;
        em_t        r;
        logic [7:0] sk, dk, ek, fdk, fek, t8;
        logic [3:0] v;
        logic       cd;
        n     = s;
        r.st  = s;
        r.ok  = 1'b1;
        r.tv  = 1'b0;
        r.tok = '0;
        sk    = stl_pkg::single_kind(c);
        dk    = stl_pkg::double_kind(c);
        ek    = stl_pkg::eq_kind(c);
        fdk   = stl_pkg::double_kind(s.win);
        fek   = stl_pkg::eq_kind(s.win);
        cd    = stl_pkg::is_digit(c);
        t8    = 8'd0;
        v     = 4'd0;
        case (s.mode)
            M_IDLE:
            begin
                n.start = pos;
                n.len   = 16'd1;
                if (c == 8'd0) begin
                    r.tv  = 1'b1;
                    r.tok = '{kind: stl_pkg::K_END, start: 16'(pos), length: 16'd1,
                              value: 32'd0, diag: 8'd0};
                    r.st  = clear(n);
                end else if (!sk[7]) begin
                    if (!dk[7] || !ek[7]) begin
                        n.mode = M_OP;
                        n.win  = c;
                        n.op2  = 1'b0;
                        r.st   = n;
                    end else begin
                        r = emit_cur(n, sk[6:0], 32'd0);
                    end
                end else if (cd) begin
                    n.mode = M_NUM_FIRST;
                    n.win  = c;
                    r.st   = n;
                end else if (stl_pkg::is_letter(c) || (c == "_")) begin
                    n.mode = M_IDENT;
                    n.kw   = stl_pkg::kw_filter(stl_pkg::KW_ALL, 16'd0, c);
                    r.st   = n;
                end else if (c inside {8'h20, 8'h09}) begin
                    n.mode = M_WS;
                    r.st   = n;
                end else if (c inside {8'h0A, 8'h0D}) begin
                    n.mode = M_NL;
                    r.st   = n;
                end else if (c inside {8'h27, 8'h22}) begin
                    n.mode = M_LIT;
                    n.win  = c;
                    r.st   = n;
                end else begin
                    n.diag = stl_pkg::D_BADB;
                    r = emit_cur(n, stl_pkg::K_BAD, 32'd0);
                end
            end
            M_OP:
            begin
                if (s.op2) begin
                    if (c == "=") begin
                        r = emit_cur(grow(s), (s.win == "<") ? stl_pkg::K_LE3 :
                                     stl_pkg::K_GE3, 32'd0);
                    end else begin
                        r    = flush(s);
                        r.ok = 1'b0;
                    end
                end else if ((s.win == "/") && (c == "/")) begin
                    n      = grow(s);
                    n.mode = M_LINE;
                    r.st   = n;
                end else if ((s.win == "/") && (c == "*")) begin
                    n       = grow(s);
                    n.mode  = M_BLK;
                    n.depth = '0;
                    r.st    = n;
                end else if ((c == s.win) && !fdk[7]) begin
                    n = grow(s);
                    if (s.win inside {8'h3C, 8'h3E}) begin
                        n.op2 = 1'b1;
                        r.st  = n;
                    end else begin
                        r = emit_cur(n, fdk[6:0], 32'd0);
                    end
                end else if ((c == "=") && !fek[7]) begin
                    r = emit_cur(grow(s), fek[6:0], 32'd0);
                end else begin
                    r    = flush(s);
                    r.ok = 1'b0;
                end
            end
            M_LINE:
            begin
                if (c inside {8'h00, 8'h0A, 8'h0D}) begin
                    r    = flush(s);
                    r.ok = 1'b0;
                end else begin
                    r.st = grow(s);
                end
            end
            M_BLK:
            begin
                if (c == 8'd0) begin
                    r    = flush(s);
                    r.ok = 1'b0;
                end else begin
                    n = grow(s);
                    if (c == "/")
                        n.mode = M_BLK_SLASH;
                    else if (c == "*")
                        n.mode = M_BLK_STAR;
                    r.st = n;
                end
            end
            M_BLK_SLASH:
            begin
                n.mode = M_BLK;
                if (c == "*") begin
                    n = grow(n);
                    if (n.depth < DW'(MAX_NEST_DEPTH))
                        n.depth = n.depth + DW'(1);
                end else begin
                    r.ok = 1'b0;
                end
                r.st = n;
            end
            M_BLK_STAR:
            begin
                n.mode = M_BLK;
                if (c == "/") begin
                    n = grow(n);
                    if (n.depth != '0) begin
                        n.depth = n.depth - DW'(1);
                        r.st    = n;
                    end else begin
                        r = emit_cur(n, stl_pkg::K_BLOCK, 32'd0);
                    end
                end else begin
                    r.ok = 1'b0;
                    r.st = n;
                end
            end
            M_NUM_FIRST:
            begin
                if (c == "x") begin
                    n      = grow(s);
                    n.mode = M_HEX;
                end else if (c == "b") begin
                    n      = grow(s);
                    n.mode = M_BIN;
                end else begin
                    n.acc = {24'd0, s.win - 8'd48};
                    if ((s.win == "0") && cd)
                        n.diag = n.diag | stl_pkg::D_LZ;
                    n.mode = M_DEC;
                    r.ok   = 1'b0;
                end
                r.st = n;
            end
            M_DEC, M_HEX, M_BIN:
            begin
                if (c == "_") begin
                    r.st = grow(s);
                end else if ((s.mode == M_DEC) && cd) begin
                    n     = grow(s);
                    t8    = c - 8'd48;
                    n.acc = {s.acc[28:0], 3'b000} + {s.acc[30:0], 1'b0} + {24'd0, t8};
                    r.st  = n;
                end else if ((s.mode == M_HEX) && (cd || stl_pkg::is_letter(c))) begin
                    if (cd)
                        t8 = c - 8'd48;
                    else if ((c >= "a") && (c <= "f"))
                        t8 = c - 8'd87;
                    else if ((c >= "A") && (c <= "F"))
                        t8 = c - 8'd55;
                    v = t8[3:0];
                    n = grow(s);
                    if ((c != "0") && (v == 4'd0))
                        n.diag = n.diag | stl_pkg::D_HEX;
                    n.acc = {s.acc[27:0], 4'b0000} + {28'd0, v};
                    r.st  = n;
                end else if ((s.mode == M_BIN) && cd) begin
                    n = grow(s);
                    if (!(c inside {8'h30, 8'h31}))
                        n.diag = n.diag | stl_pkg::D_BIN;
                    t8    = c - 8'd48;
                    n.acc = {s.acc[30:0], 1'b0} + {24'd0, t8};
                    r.st  = n;
                end else begin
                    r    = flush(s);
                    r.ok = 1'b0;
                end
            end
            M_LIT:
            begin
                n = grow(s);
                if (c == "\\") begin
                    n.mode = M_LIT_ESC;
                    r.st   = n;
                end else if (c inside {8'h00, 8'h0A, 8'h0D}) begin
                    n.diag = n.diag | stl_pkg::D_UNEXP;
                    r = finish_lit(n);
                end else if (c == s.win) begin
                    r = finish_lit(n);
                end else begin
                    r.st = add_content(n, c);
                end
            end
            M_LIT_ESC:
            begin
                if (c == "r")
                    t8 = 8'd13;
                else if (c == "n")
                    t8 = 8'd10;
                else if (c == "0")
                    t8 = 8'd0;
                else
                    t8 = c;
                n      = add_content(grow(s), t8);
                n.mode = M_LIT;
                r.st   = n;
            end
            M_IDENT:
            begin
                if (!stl_pkg::is_ident(c)) begin
                    r    = flush(s);
                    r.ok = 1'b0;
                end else begin
                    n.kw = stl_pkg::kw_filter(s.kw, s.len, c);
                    r.st = grow(n);
                end
            end
            M_WS:
            begin
                if (!(c inside {8'h20, 8'h09})) begin
                    r    = flush(s);
                    r.ok = 1'b0;
                end else begin
                    r.st = grow(s);
                end
            end
            M_NL:
            begin
                if (!(c inside {8'h0A, 8'h0D})) begin
                    r    = flush(s);
                    r.ok = 1'b0;
                end else begin
                    r.st = grow(s);
                end
            end
            default:
            begin
                r.st = clear(s);
                r.ok = 1'b0;
            end
        endcase
        return r;
    endfunction

    lex_st_t                  st_reg, st_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next, pos_inc;
    em_t                      e1, e2, e3, fl;
    stl_pkg::token_t          cand [5];
    logic [4:0]               cv;
    logic [2:0]               cnt;
    logic                     accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // a byte is re-examined at most twice: after a number's first digit or a
    // comment's slash/star, and after the pending token is flushed
    always_comb
    begin
        e1 = feed(st_reg, in_byte, pos_reg);
        e2 = e1;
        e2.tv = 1'b0;
        if (!e1.ok)
            e2 = feed(e1.st, in_byte, pos_reg);
        e3 = e2;
        e3.tv = 1'b0;
        if (!e2.ok)
            e3 = feed(e2.st, in_byte, pos_reg);

        pos_inc = pos_reg + POSITION_BITS'(1);
        fl      = e3;
        fl.tv   = 1'b0;
        cv      = {in_end, 1'b0, e3.tv, e2.tv, e1.tv};
        cand[0] = e1.tok;
        cand[1] = e2.tok;
        cand[2] = e3.tok;
        cand[4] = '{kind: stl_pkg::K_END, start: 16'(pos_inc), length: 16'd1,
                    value: 32'd0, diag: 8'd0};
        if (in_end) begin
            fl       = flush(e3.st);
            cv[3]    = fl.tv;
            st_next  = ST_RESET;
            pos_next = '0;
        end else begin
            st_next  = e3.st;
            pos_next = pos_inc;
        end
        cand[3] = fl.tok;

        cnt          = 3'd0;
        q_bundle.tok = '0;
        for (int i = 0; i < 5; i++) begin
            if (cv[i] && (cnt < 3'(stl_pkg::TOKENS_PER_BYTE))) begin
                q_bundle.tok[cnt[1:0]] = cand[i];
                cnt = cnt + 3'd1;
            end
        end
        q_bundle.count = cnt;
        q_push         = accept && (cnt != 3'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            st_reg  <= ST_RESET;
            pos_reg <= '0;
        end else if (accept) begin
            st_reg  <= st_next;
            pos_reg <= pos_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/stl_queue.sv =====
// ----------------------------------------------------------------------------
// stl_queue
// Two-entry queue of token bundles between the lexer and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module stl_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire stl_pkg::bundle_t din,
    output      logic             full,
    input  wire logic             pop,
    output      stl_pkg::bundle_t dout,
    output      logic             empty
);

    stl_pkg::bundle_t mem_reg [2];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       count_reg;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign dout  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= din;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/stl_back.sv =====
// ----------------------------------------------------------------------------
// stl_back
// Output stage: sends the tokens of the head bundle one transfer at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module stl_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire stl_pkg::bundle_t head,
    input  wire logic             empty,
    output      logic             pop,
    output      logic             out_valid,
    input  wire logic             out_ready,
    output      stl_pkg::token_t  out_tok,
    output      logic             out_last
);

    logic [1:0] idx_reg;

    assign out_valid = !empty;
    assign out_tok   = head.tok[idx_reg];
    assign out_last  = ({1'b0, idx_reg} == (head.count - 3'd1));
    assign pop       = out_valid && out_ready && out_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= 2'd0;
        else if (out_valid && out_ready)
            idx_reg <= out_last ? 2'd0 : idx_reg + 2'd1;
    end

endmodule

`default_nettype wire

// ===== rtl/source_token_lexer.sv =====
// ----------------------------------------------------------------------------
// source_token_lexer
// Streaming lexer: one source byte in, tokens with span, value and diagnostics out.
// ----------------------------------------------------------------------------
// Path: the tokens a byte completes pass through a registered two-bundle queue to the output.
// Throughput: one byte per cycle while each byte yields at most one token and m_tready
//   stays high; the tokens of a byte (up to 4) leave one per cycle through the output
//   stage behind a two-bundle queue, and the input stalls while that queue is full.
// Reset: asynchronous; lexer idle, position zero, queue empty.
`default_nettype none

module source_token_lexer #(
    parameter int POSITION_BITS  = stl_pkg::POSITION_BITS_DEF,
    parameter int MAX_NEST_DEPTH = stl_pkg::MAX_NEST_DEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // text_byte
    input  wire logic        s_tlast,   // text_end
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [71:0] m_tdata,   // token_start, token_length, token_value, diag_flags
    output      logic [6:0]  m_tuser,   // token_kind
    output      logic        m_tlast    // result_last
);

    stl_pkg::bundle_t q_in, q_out;
    stl_pkg::token_t  tok;
    logic             q_push, q_pop, q_full, q_empty;

    stl_front #(
        .POSITION_BITS  (POSITION_BITS),
        .MAX_NEST_DEPTH (MAX_NEST_DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_byte  (s_tdata),
        .in_end   (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_bundle (q_in)
    );

    stl_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_in),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (q_out),
        .empty (q_empty)
    );

    stl_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_out),
        .empty     (q_empty),
        .pop       (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_tok   (tok),
        .out_last  (m_tlast)
    );

    assign m_tdata = {tok.diag, tok.value, tok.length, tok.start};
    assign m_tuser = tok.kind;

endmodule

`default_nettype wire

// ===== dv/source_token_lexer_checker.sv =====
// ----------------------------------------------------------------------------
// source_token_lexer_checker
// Watches the byte and token streams of the lexer, predicts the tokens that
// every accepted byte produces, and compares them field by field in order.
// ----------------------------------------------------------------------------
`default_nettype none

module source_token_lexer_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // text_byte
    input  wire logic        s_tlast,   // text_end
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [71:0] m_tdata,   // token_start, token_length, token_value, diag_flags
    input  wire logic [6:0]  m_tuser,   // token_kind
    input  wire logic        m_tlast,   // result_last
    output int               errors,
    output int               pending,
    output int               tokens_seen
);

    typedef enum logic [4:0] {
        LX_IDLE, LX_OP, LX_LINE, LX_BLK, LX_BLK_SLASH, LX_BLK_STAR, LX_NUM_FIRST,
        LX_DEC, LX_HEX, LX_BIN, LX_LIT, LX_LIT_ESC, LX_IDENT, LX_WS, LX_NL
    } lex_mode_e;

    typedef struct {
        logic [6:0]  kind;
        logic [15:0] start;
        logic [15:0] length;
        logic [31:0] value;
        logic [7:0]  diag;
        logic        last;
    } token_rec_t;

    localparam int NO_OP    = -1;
    localparam int KW_TRUE  = 0;
    localparam int MAX_TOKS = 4;

    string kw_word [15] = '{"true", "false", "if", "else", "switch", "case", "default",
        "while", "for", "in", "break", "continue", "fn", "namespace", "enum"};
    string op_single = "+-*/%!=<>&|~^?:;,.(){}";
    int    op_single_kind [22] = '{0, 3, 6, 8, 10, 12, 14, 16, 20, 24, 27, 30, 31, 33,
        34, 35, 36, 37, 39, 40, 41, 42};
    string op_double = "+-<>&|.";
    int    op_double_kind [7] = '{1, 4, 18, 22, 25, 28, 38};
    string op_assign = "+-*/%!=<>&|^";
    int    op_assign_kind [12] = '{2, 5, 7, 9, 11, 13, 15, 17, 21, 26, 29, 32};

    token_rec_t  expected_tokens [$];
    lex_mode_e   mode;
    logic [7:0]  window;
    logic [1:0]  window_cnt;
    logic [15:0] pos, tok_start, tok_len;
    logic [31:0] acc;
    logic [7:0]  depth, diags;
    logic [14:0] kw_mask;
    logic [1:0]  lit_cnt;
    int          step_count;

    function automatic int op_lookup(string chars, int kinds [], logic [7:0] c);
        for (int i = 0; i < chars.len(); i++)
            if (chars[i] == c) return kinds[i];
        return NO_OP;
    endfunction

    function automatic int single_op(logic [7:0] c);
        return op_lookup(op_single, op_single_kind, c);
    endfunction

    function automatic int double_op(logic [7:0] c);
        return op_lookup(op_double, op_double_kind, c);
    endfunction

    function automatic int assign_op(logic [7:0] c);
        return op_lookup(op_assign, op_assign_kind, c);
    endfunction

    function automatic bit digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic [14:0] narrow_keywords(logic [14:0] m, int idx, logic [7:0] c);
        logic [14:0] r;
        r = '0;
        for (int k = 0; k < 15; k++)
            if (m[k] && idx < kw_word[k].len() && kw_word[k][idx] == c) r[k] = 1'b1;
        return r;
    endfunction

    function automatic void clear_lexeme();
        mode = LX_IDLE; window = '0; window_cnt = '0; acc = '0; depth = '0;
        kw_mask = stl_pkg::KW_ALL; lit_cnt = '0; diags = '0; tok_len = '0;
    endfunction

    function automatic void push_token(logic [6:0] k, logic [15:0] st, logic [15:0] ln,
                                       logic [31:0] v, logic [7:0] d);
        token_rec_t t;
        if (step_count < MAX_TOKS) begin
            t.kind = k; t.start = st; t.length = ln; t.value = v; t.diag = d; t.last = 1'b0;
            expected_tokens.push_back(t);
            step_count++;
        end
        clear_lexeme();
    endfunction

    function automatic void push_current(logic [6:0] k, logic [31:0] v);
        push_token(k, tok_start, tok_len, v, diags);
    endfunction

    function automatic void extend();
        if (tok_len != 16'hFFFF) tok_len++;
    endfunction

    function automatic void add_char(logic [7:0] code);
        if (lit_cnt == 0) acc = {24'd0, code};
        if (lit_cnt < 2) lit_cnt++;
    endfunction

    function automatic void close_literal();
        if (window == "'") begin
            if (lit_cnt == 0) diags |= stl_pkg::D_EMPTY;
            if (lit_cnt >= 2) diags |= stl_pkg::D_LONG;
            push_current(stl_pkg::K_CHAR, lit_cnt != 0 ? acc : 32'd0);
        end else begin
            push_current(stl_pkg::K_STR, 32'd0);
        end
    endfunction

    function automatic void close_number();
        push_current((diags & (stl_pkg::D_LZ | stl_pkg::D_HEX | stl_pkg::D_BIN)) != 0 ?
                     stl_pkg::K_BAD : stl_pkg::K_NUM, acc);
    endfunction

    function automatic void close_ident();
        logic [6:0]  k;
        logic [31:0] v;
        k = stl_pkg::K_IDENT;
        v = '0;
        for (int i = 0; i < 15; i++)
            if (kw_mask[i] && tok_len == kw_word[i].len()) begin
                k = stl_pkg::K_KW0 + 7'(i);
                v = (i == KW_TRUE) ? 32'd1 : 32'd0;
            end
        push_current(k, v);
    endfunction

    // finish whatever is pending as if the text stopped here
    function automatic void flush_lexeme();
        case (mode)
            LX_OP:
                push_current(7'(window_cnt >= 2 ? double_op(window) : single_op(window)), 0);
            LX_LINE: push_current(stl_pkg::K_LINE, 0);
            LX_BLK, LX_BLK_SLASH, LX_BLK_STAR:
            begin
                diags |= stl_pkg::D_UNTERM;
                push_current(stl_pkg::K_BLOCK, 0);
            end
            LX_NUM_FIRST:
            begin
                acc = {24'd0, window - 8'd48};
                close_number();
            end
            LX_DEC, LX_HEX, LX_BIN: close_number();
            LX_LIT_ESC:
            begin
                add_char(8'd0);
                close_literal();
            end
            LX_LIT:   close_literal();
            LX_IDENT: close_ident();
            LX_WS:    push_current(stl_pkg::K_WS, 0);
            LX_NL:    push_current(stl_pkg::K_NL, 0);
            default:  clear_lexeme();
        endcase
    endfunction

    // returns 1 when the byte is consumed, 0 when it must be fed again
    function automatic bit lex_byte(logic [7:0] c);
        logic [7:0] f, v;
        case (mode)
            LX_IDLE:
            begin
                tok_start = pos;
                tok_len = 16'd1;
                if (c == 8'd0) begin
                    push_token(stl_pkg::K_END, pos, 16'd1, 0, 0);
                end else if (single_op(c) != NO_OP) begin
                    if (double_op(c) != NO_OP || assign_op(c) != NO_OP) begin
                        mode = LX_OP; window = c; window_cnt = 2'd1;
                    end else begin
                        push_current(7'(single_op(c)), 0);
                    end
                end else if (digit(c)) begin
                    mode = LX_NUM_FIRST; window = c;
                end else if (letter(c) || c == "_") begin
                    mode = LX_IDENT; kw_mask = narrow_keywords(stl_pkg::KW_ALL, 0, c);
                end else if (c == " " || c == "\t") begin
                    mode = LX_WS;
                end else if (c == "\n" || c == "\r") begin
                    mode = LX_NL;
                end else if (c == "'" || c == "\"") begin
                    mode = LX_LIT; window = c;
                end else begin
                    diags = stl_pkg::D_BADB;
                    push_current(stl_pkg::K_BAD, 0);
                end
                return 1;
            end
            LX_OP:
            begin
                f = window;
                if (window_cnt >= 2) begin
                    if (c == "=") begin
                        extend();
                        push_current(f == "<" ? stl_pkg::K_LE3 : stl_pkg::K_GE3, 0);
                        return 1;
                    end
                    flush_lexeme();
                    return 0;
                end
                if (f == "/" && c == "/") begin extend(); mode = LX_LINE; return 1; end
                if (f == "/" && c == "*") begin
                    extend(); mode = LX_BLK; depth = '0; return 1;
                end
                if (c == f && double_op(f) != NO_OP) begin
                    extend();
                    if (f == "<" || f == ">") window_cnt = 2'd2;
                    else push_current(7'(double_op(f)), 0);
                    return 1;
                end
                if (c == "=" && assign_op(f) != NO_OP) begin
                    extend();
                    push_current(7'(assign_op(f)), 0);
                    return 1;
                end
                flush_lexeme();
                return 0;
            end
            LX_LINE:
            begin
                if (c == 8'd0 || c == "\n" || c == "\r") begin flush_lexeme(); return 0; end
                extend();
                return 1;
            end
            LX_BLK:
            begin
                if (c == 8'd0) begin flush_lexeme(); return 0; end
                extend();
                if (c == "/") mode = LX_BLK_SLASH;
                else if (c == "*") mode = LX_BLK_STAR;
                return 1;
            end
            LX_BLK_SLASH:
            begin
                mode = LX_BLK;
                if (c == "*") begin
                    extend();
                    if (depth < 8'(stl_pkg::MAX_NEST_DEPTH_DEF)) depth++;
                    return 1;
                end
                return 0;
            end
            LX_BLK_STAR:
            begin
                mode = LX_BLK;
                if (c == "/") begin
                    extend();
                    if (depth > 0) depth--;
                    else push_current(stl_pkg::K_BLOCK, 0);
                    return 1;
                end
                return 0;
            end
            LX_NUM_FIRST:
            begin
                if (c == "x") begin extend(); mode = LX_HEX; return 1; end
                if (c == "b") begin extend(); mode = LX_BIN; return 1; end
                acc = {24'd0, window - 8'd48};
                if (window == "0" && digit(c)) diags |= stl_pkg::D_LZ;
                mode = LX_DEC;
                return 0;
            end
            LX_DEC, LX_HEX, LX_BIN:
            begin
                if (c == "_") begin extend(); return 1; end
                if (mode == LX_DEC && digit(c)) begin
                    extend();
                    acc = acc * 10 + 32'(c - 8'd48);
                    return 1;
                end
                if (mode == LX_HEX && (digit(c) || letter(c))) begin
                    v = '0;
                    if (digit(c)) v = c - 8'd48;
                    else if (c >= "a" && c <= "f") v = c - 8'd87;
                    else if (c >= "A" && c <= "F") v = c - 8'd55;
                    if (c != "0" && v == 0) diags |= stl_pkg::D_HEX;
                    extend();
                    acc = (acc << 4) + 32'(v);
                    return 1;
                end
                if (mode == LX_BIN && digit(c)) begin
                    if (c != "0" && c != "1") diags |= stl_pkg::D_BIN;
                    extend();
                    acc = (acc << 1) + 32'(c - 8'd48);
                    return 1;
                end
                flush_lexeme();
                return 0;
            end
            LX_LIT:
            begin
                extend();
                if (c == "\\") mode = LX_LIT_ESC;
                else if (c == 8'd0 || c == "\n" || c == "\r") begin
                    diags |= stl_pkg::D_UNEXP;
                    close_literal();
                end
                else if (c == window) close_literal();
                else add_char(c);
                return 1;
            end
            LX_LIT_ESC:
            begin
                extend();
                add_char(c == "r" ? 8'd13 : c == "n" ? 8'd10 : c == "0" ? 8'd0 : c);
                mode = LX_LIT;
                return 1;
            end
            LX_IDENT:
            begin
                if (!(letter(c) || digit(c) || c == "_")) begin flush_lexeme(); return 0; end
                kw_mask = narrow_keywords(kw_mask, int'(tok_len), c);
                extend();
                return 1;
            end
            LX_WS:
            begin
                if (c != " " && c != "\t") begin flush_lexeme(); return 0; end
                extend();
                return 1;
            end
            LX_NL:
            begin
                if (c != "\n" && c != "\r") begin flush_lexeme(); return 0; end
                extend();
                return 1;
            end
            default:
            begin
                clear_lexeme();
                return 0;
            end
        endcase
    endfunction

    function automatic void predict_byte(logic [7:0] c, logic text_end);
        step_count = 0;
        for (int i = 0; i < 4; i++)
            if (lex_byte(c)) break;
        pos++;
        if (text_end) begin
            flush_lexeme();
            push_token(stl_pkg::K_END, pos, 16'd1, 0, 0);
            clear_lexeme();
            pos = '0;
            tok_start = '0;
        end
        if (step_count > 0) expected_tokens[expected_tokens.size() - 1].last = 1'b1;
    endfunction

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        token_rec_t t;
        if (!rst_n) begin
            clear_lexeme();
            pos = '0;
            tok_start = '0;
            expected_tokens.delete();
        end else begin
            if (s_tvalid && s_tready) predict_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                tokens_seen++;
                if (expected_tokens.size() == 0) begin
                    $error("unexpected token: kind %0d start %0d", m_tuser, m_tdata[15:0]);
                    errors++;
                end else begin
                    t = expected_tokens.pop_front();
                    check_field("token_kind", 32'(t.kind), 32'(m_tuser));
                    check_field("token_start", 32'(t.start), 32'(m_tdata[15:0]));
                    check_field("token_length", 32'(t.length), 32'(m_tdata[31:16]));
                    check_field("token_value", t.value, m_tdata[63:32]);
                    check_field("diag_flags", 32'(t.diag), 32'(m_tdata[71:64]));
                    check_field("result_last", 32'(t.last), 32'(m_tlast));
                end
            end
        end
        pending = expected_tokens.size();
    end

    initial begin
        errors = 0;
        pending = 0;
        tokens_seen = 0;
    end

endmodule

`default_nettype wire

// ===== dv/source_token_lexer_test.sv =====
// ----------------------------------------------------------------------------
// source_token_lexer_test
// Feeds the lexer directed snippets and random source fragments under random
// flow control; the checker beside the block predicts and compares tokens.
// ----------------------------------------------------------------------------
`default_nettype none

module source_token_lexer_test;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int BYTE_TARGET    = 360;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // text_byte
    logic        s_tlast;   // text_end
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;   // token_start, token_length, token_value, diag_flags
    logic [6:0]  m_tuser;   // token_kind
    logic        m_tlast;   // result_last
    int          errors, pending, tokens_seen;
    int          bytes_sent, idle_cycles;
    bit          calm;
    logic [7:0]  text_q [$];

    source_token_lexer DUT (.*);

    source_token_lexer_checker checker_i (.*);

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // output stalls; none while calm
    always @(negedge clk) m_tready <= calm || ($urandom_range(99) >= 17);

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_byte(logic [7:0] b, logic text_end);
        while (!calm && $urandom_range(99) < 17) begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        s_tlast  = text_end;
        do @(posedge clk); while (!s_tready);
        bytes_sent++;
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    task automatic queue_text(string s);
        for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    endtask

    // send everything queued; text_end on the last byte if asked
    task automatic send_text(bit end_it);
        logic [7:0] b;
        while (text_q.size() > 0) begin
            b = text_q.pop_front();
            send_byte(b, end_it && text_q.size() == 0);
        end
    endtask

    function automatic logic [7:0] pick(string s);
        return s[$urandom_range(s.len() - 1)];
    endfunction

    task automatic random_fragment();
        string kws [15] = '{"true", "false", "if", "else", "switch", "case", "default",
            "while", "for", "in", "break", "continue", "fn", "namespace", "enum"};
        string ops [10] = '{"<<=", ">>=", "&&", "||", "++", "..", "!=", "^=", "~", "%"};
        string ident_chars = "abcdefghinorstuwxyzAZ_0189";
        int n;
        n = $urandom_range(1, 10);
        case ($urandom_range(11))
            0:
            begin
                if ($urandom_range(1)) queue_text(kws[$urandom_range(14)]);
                else repeat (n) text_q.push_back(pick(ident_chars));
            end
            1: repeat (n + 2) text_q.push_back(pick("0123456789_"));
            2:
            begin
                queue_text($urandom_range(1) ? "0x" : "7x");
                repeat (n) text_q.push_back(pick("0123456789abcdefABCDEF_g"));
            end
            3:
            begin
                queue_text("0b");
                repeat (n * 3) text_q.push_back(pick("0101101_2"));
            end
            4:
            begin
                text_q.push_back("'");
                repeat ($urandom_range(2)) begin
                    if ($urandom_range(3) == 0) text_q.push_back("\\");
                    text_q.push_back(8'($urandom_range(32, 126)));
                end
                text_q.push_back("'");
            end
            5:
            begin
                text_q.push_back("\"");
                repeat (n) text_q.push_back(pick("ab \\n0r'\"\\z"));
                text_q.push_back("\"");
            end
            6: queue_text(ops[$urandom_range(9)]);
            7:
            begin
                queue_text("//");
                repeat (n) text_q.push_back(8'($urandom_range(32, 255)));
                text_q.push_back("\n");
            end
            8:
            begin
                queue_text("/*");
                repeat (n) text_q.push_back(pick("a */*/ /*x*"));
                queue_text("*/");
            end
            9: repeat (n) text_q.push_back(pick(" \t\r\n"));
            10: repeat ($urandom_range(1, 3)) text_q.push_back(8'($urandom_range(255)));
            default: queue_text($urandom_range(1) ? "/* open" : "'ab");
        endcase
        if ($urandom_range(2) == 0) text_q.push_back(" ");
    endtask

    initial begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        calm = 1'b0;
        bytes_sent = 0;
        idle_cycles = 0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // directed: number forms and checks, literals, comments, operators, bad bytes
        queue_text("0xFfffFFFF 0x1g 0b1_02 007 99999999999 5");
        send_text(1'b1);
        queue_text("'a' '' 'ab' '\\n' \"s\\\"t\" '\n");
        send_text(1'b0);
        queue_text("/* a /* b */ */ // c\r\n<<= >>= >> && |= .. ( @\\");
        send_text(1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b0);
        queue_text("namespace true false continue fn x_1 /* open");
        send_text(1'b0);
        send_byte(8'h00, 1'b0);
        queue_text("'x\\");
        send_text(1'b1);
        queue_text("+");
        send_text(1'b1);

        while (bytes_sent < BYTE_TARGET) begin
            calm = bytes_sent > 250 && bytes_sent < 330;
            random_fragment();
            send_text($urandom_range(29) == 0);
        end
        calm = 1'b0;
        send_byte(" ", 1'b1);

        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("Lexed %0d source bytes into %0d checked tokens.", bytes_sent, tokens_seen);
        $display("Covered numbers, literals, nested comments, operators and bad bytes.");
        if (errors == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
